@@ hw/rtl/hnst_pkg.sv @@
// shared types, constants and the hash step for the host name slot table
`timescale 1ns / 1ps
`default_nettype none

package hnst_pkg;

   localparam int FNV_W      = 32;
   localparam logic [FNV_W-1:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [FNV_W-1:0] FNV_PRIME = 32'h01000193;
   localparam int BYTE_W     = 8;
   localparam int MOD_STEPS  = FNV_W / BYTE_W;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);
   localparam int SLOT_OUT_W = 7;
   localparam int BYTE_IDX_W = 8;
   localparam int STATUS_W   = 3;

   typedef enum logic {
      ACT_RESOLVE = 1'b0,
      ACT_READ    = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND    = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADLEN   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MOD,
      S_PROBE,
      S_LEN_WAIT,
      S_CMP,
      S_END,
      S_COPY,
      S_RD_ISSUE,
      S_RD_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic absorb;
      logic clear;
      logic mod_start;
   } intake_ctrl_type;

   typedef struct packed {
      logic set_used;
      logic len_wr;
      logic store_wr;
   } table_ctrl_type;

   // one fnv-1a step: xor in the byte, multiply by the prime mod 2^32
   function automatic logic [FNV_W-1:0] fnv_step(input logic [FNV_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
      logic [FNV_W-1:0] m;
      m = h ^ {{(FNV_W-BYTE_W){1'b0}}, b};
      return m * FNV_PRIME;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hnst_req_if.sv @@
// request channel: name bytes and stored byte reads
`timescale 1ns / 1ps
`default_nettype none

interface hnst_req_if import hnst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [BYTE_W-1:0]     name_byte;
   logic                  last;
   logic [SLOT_OUT_W-1:0] slot_index;
   logic [BYTE_IDX_W-1:0] byte_index;

   modport source (output valid, action, name_byte, last, slot_index, byte_index,
                   input ready);
   modport sink (input valid, action, name_byte, last, slot_index, byte_index,
                 output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hnst_rsp_if.sv @@
// response channel: slot, status and stored byte
`timescale 1ns / 1ps
`default_nettype none

interface hnst_rsp_if import hnst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_OUT_W-1:0] slot;
   logic [STATUS_W-1:0]   status;
   logic [BYTE_W-1:0]     host_byte;

   modport source (output valid, slot, status, host_byte, input ready);
   modport sink (input valid, slot, status, host_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hnst_intake.sv @@
// incoming name buffer, running fnv-1a hash and byte-wise modulo unit
`timescale 1ns / 1ps
`default_nettype none

module hnst_intake import hnst_pkg::*; #(
   parameter int TABLE_SLOTS    = 128,
   parameter int NAME_MAX_BYTES = 253,
   localparam int SLOT_W = $clog2(TABLE_SLOTS),
   localparam int LEN_W  = $clog2(NAME_MAX_BYTES + 2),
   localparam int IDX_W  = $clog2(NAME_MAX_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  intake_ctrl_type   ctrl,
   input  logic [BYTE_W-1:0] name_byte,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [LEN_W-1:0]  in_len,
   output logic [BYTE_W-1:0] rd_byte,
   output logic              mod_done,
   output logic [SLOT_W-1:0] first_slot
);

   // reciprocal for the 16-bit fold, exact for every fold below 2^16
   localparam int RECIP_SH = 24;
   localparam int FOLD_W   = 2 * BYTE_W;
   localparam int PROD_W   = FOLD_W + RECIP_SH;
   localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / TABLE_SLOTS + 1);

   logic [FNV_W-1:0]     hash_ff, hash_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 zero_ff, zero_in;
   logic                 wr_en;
   logic [BYTE_W-1:0]    name_mem [NAME_MAX_BYTES];
   logic [BYTE_W-1:0]    rd_byte_ff;

   logic [FNV_W-1:0]     shreg_ff;
   logic [SLOT_W-1:0]    rem_ff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [FOLD_W-1:0]    fold;
   logic [PROD_W-1:0]    fold_prod;
   logic [FOLD_W-1:0]    fold_quot;
   logic [FOLD_W-1:0]    fold_rem;

   always_comb begin
      hash_in = hash_ff;
      len_in  = len_ff;
      zero_in = zero_ff;
      wr_en   = 1'b0;
      if (ctrl.clear) begin
         hash_in = FNV_BASIS;
         len_in  = '0;
         zero_in = 1'b0;
      end else if (ctrl.absorb && !zero_ff) begin
         if (name_byte == '0) begin
            zero_in = 1'b1;
         end else if (32'(len_ff) <= NAME_MAX_BYTES) begin
            len_in  = len_ff + LEN_W'(1);
            hash_in = fnv_step(hash_ff, name_byte);
            wr_en   = (32'(len_ff) < NAME_MAX_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         len_ff  <= '0;
         zero_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[len_ff[IDX_W-1:0]] <= name_byte;
      end
      rd_byte_ff <= name_mem[rd_idx];
   end

   // horner remainder, one hash byte per cycle from the top: r = (r*256 + b) mod slots
   assign fold      = {BYTE_W'(rem_ff), shreg_ff[FNV_W-1 -: BYTE_W]};
   assign fold_prod = PROD_W'(fold) * PROD_W'(RECIP);
   assign fold_quot = fold_prod[PROD_W-1 -: FOLD_W];
   assign fold_rem  = fold - fold_quot * FOLD_W'(TABLE_SLOTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
         if (ctrl.mod_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + MOD_CNT_W'(1);
            if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mod_start) begin
         shreg_ff <= hash_ff;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shreg_ff <= {shreg_ff[FNV_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
         rem_ff   <= fold_rem[SLOT_W-1:0];
      end
   end

   assign in_len     = len_ff;
   assign rd_byte    = rd_byte_ff;
   assign mod_done   = done_ff;
   assign first_slot = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hnst_table.sv @@
// slot used flags, stored name lengths and the name store memory
`timescale 1ns / 1ps
`default_nettype none

module hnst_table import hnst_pkg::*; #(
   parameter int TABLE_SLOTS    = 128,
   parameter int NAME_MAX_BYTES = 253,
   localparam int SLOT_W = $clog2(TABLE_SLOTS),
   localparam int LEN_W  = $clog2(NAME_MAX_BYTES + 2),
   localparam int ADDR_W = $clog2(TABLE_SLOTS * NAME_MAX_BYTES + 256)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  table_ctrl_type        ctrl,
   input  logic [SLOT_W-1:0]     rd_slot,
   input  logic [BYTE_IDX_W-1:0] rd_idx,
   input  logic [SLOT_W-1:0]     wr_slot,
   input  logic [BYTE_IDX_W-1:0] wr_idx,
   input  logic [LEN_W-1:0]      wr_len,
   input  logic [BYTE_W-1:0]     wr_byte,
   output logic                  used_bit,
   output logic [LEN_W-1:0]      len_rd,
   output logic [BYTE_W-1:0]     store_rd
);

   logic [TABLE_SLOTS-1:0] used_ff;
   logic [LEN_W-1:0]       len_mem [TABLE_SLOTS];
   logic [BYTE_W-1:0]      store_mem [TABLE_SLOTS * NAME_MAX_BYTES];
   logic [LEN_W-1:0]       len_rd_ff;
   logic [BYTE_W-1:0]      store_rd_ff;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;

   assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(NAME_MAX_BYTES) + ADDR_W'(rd_idx);
   assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(NAME_MAX_BYTES) + ADDR_W'(wr_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (ctrl.set_used) begin
         used_ff[wr_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.len_wr) begin
         len_mem[wr_slot] <= wr_len;
      end
      len_rd_ff <= len_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (ctrl.store_wr) begin
         store_mem[wr_addr] <= wr_byte;
      end
      store_rd_ff <= store_mem[rd_addr];
   end

   assign used_bit = used_ff[rd_slot];
   assign len_rd   = len_rd_ff;
   assign store_rd = store_rd_ff;

endmodule

`default_nettype wire

@@ hw/rtl/host_name_slot_table_top.sv @@
// host name slot table: fnv-1a hashed table with linear probing, top level
// non-final name byte: accepted in idle, no response; bad length: the check state goes straight to done
// final byte otherwise: check, modulo, probe walk, end when no match is found (plus a copy of the name
//    on insert), then done; the walk reads each slot's used flag, a used slot's length, and bytes on a length match
// stored byte read: issue, wait for the stored byte (skipped for an unused slot), then done; the next transfer
//    is taken back in idle; one item in work at a time, a full output register holds the sequencer
// synchronous active-high reset clears used flags, hash, length and control
`timescale 1ns / 1ps
`default_nettype none

module host_name_slot_table_top import hnst_pkg::*; #(
   parameter int TABLE_SLOTS    = 128,
   parameter int NAME_MAX_BYTES = 253
) (
   input logic        clock,
   input logic        reset,
   hnst_req_if.sink   req_bus,
   hnst_rsp_if.source rsp_bus
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int LEN_W  = $clog2(NAME_MAX_BYTES + 2);
   localparam int IDX_W  = $clog2(NAME_MAX_BYTES + 1);

   state_type state_ff, state_in;

   // latched read request
   logic [SLOT_OUT_W-1:0] sidx_ff, sidx_in;
   logic [BYTE_IDX_W-1:0] bidx_ff, bidx_in;
   logic                  read_ff, read_in;

   // probe walk
   logic [SLOT_W-1:0] s_ff, s_in;
   logic [SLOT_W-1:0] off_ff, off_in;
   logic [SLOT_W-1:0] avail_ff, avail_in;
   logic              avail_vld_ff, avail_vld_in;
   logic [LEN_W-1:0]  i_ff, i_in;

   // result held until the output register frees up
   logic [SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;
   status_type            res_status_ff, res_status_in;
   logic [BYTE_W-1:0]     res_byte_ff, res_byte_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;

   intake_ctrl_type       ictrl;
   table_ctrl_type        tctrl;
   logic                  req_xfer;
   logic [LEN_W-1:0]      in_len;
   logic [BYTE_W-1:0]     in_rd_byte;
   logic                  mod_done;
   logic [SLOT_W-1:0]     first_slot;
   logic [LEN_W-1:0]      rd_i;
   logic [SLOT_W-1:0]     rd_slot;
   logic [BYTE_IDX_W-1:0] rd_idx;
   logic                  used_bit;
   logic [LEN_W-1:0]      len_rd;
   logic [BYTE_W-1:0]     store_rd;
   logic                  walk_end;
   logic [SLOT_W-1:0]     s_next;

   assign req_xfer = req_bus.valid && req_bus.ready;

   // read index for the next cycle: first byte on entry, then one past the current
   assign rd_i    = (state_ff == S_CMP || state_ff == S_COPY) ? i_ff + LEN_W'(1) : '0;
   assign rd_slot = (state_ff == S_RD_ISSUE) ? SLOT_W'(sidx_ff) : s_ff;
   assign rd_idx  = (state_ff == S_RD_ISSUE) ? bidx_ff : BYTE_IDX_W'(rd_i);

   // wrap-around step of the walk
   assign walk_end = (off_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign s_next   = (s_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : s_ff + SLOT_W'(1);

   hnst_intake #(
      .TABLE_SLOTS    (TABLE_SLOTS),
      .NAME_MAX_BYTES (NAME_MAX_BYTES)
   ) u_intake (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ictrl),
      .name_byte  (req_bus.name_byte),
      .rd_idx     (rd_i[IDX_W-1:0]),
      .in_len     (in_len),
      .rd_byte    (in_rd_byte),
      .mod_done   (mod_done),
      .first_slot (first_slot)
   );

   hnst_table #(
      .TABLE_SLOTS    (TABLE_SLOTS),
      .NAME_MAX_BYTES (NAME_MAX_BYTES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tctrl),
      .rd_slot  (rd_slot),
      .rd_idx   (rd_idx),
      .wr_slot  (avail_ff),
      .wr_idx   (BYTE_IDX_W'(i_ff)),
      .wr_len   (in_len),
      .wr_byte  (in_rd_byte),
      .used_bit (used_bit),
      .len_rd   (len_rd),
      .store_rd (store_rd)
   );

   always_comb begin
      state_in      = state_ff;
      sidx_in       = sidx_ff;
      bidx_in       = bidx_ff;
      read_in       = read_ff;
      s_in          = s_ff;
      off_in        = off_ff;
      avail_in      = avail_ff;
      avail_vld_in  = avail_vld_ff;
      i_in          = i_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      ictrl         = '0;
      tctrl         = '0;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_xfer) begin
               if (req_bus.action == ACT_READ) begin
                  sidx_in  = req_bus.slot_index;
                  bidx_in  = req_bus.byte_index;
                  read_in  = 1'b1;
                  state_in = S_RD_ISSUE;
               end else begin
                  ictrl.absorb = 1'b1;
                  if (req_bus.last) begin
                     read_in  = 1'b0;
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            // empty name or one that ran past the limit
            if (in_len == '0 || 32'(in_len) > NAME_MAX_BYTES) begin
               res_slot_in   = '0;
               res_status_in = ST_BADLEN;
               res_byte_in   = '0;
               state_in      = S_DONE;
            end else begin
               ictrl.mod_start = 1'b1;
               state_in        = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               s_in         = first_slot;
               off_in       = '0;
               avail_vld_in = 1'b0;
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            if (used_bit) begin
               state_in = S_LEN_WAIT;
            end else begin
               if (!avail_vld_ff) begin
                  avail_in     = s_ff;
                  avail_vld_in = 1'b1;
               end
               off_in   = off_ff + SLOT_W'(1);
               s_in     = s_next;
               state_in = walk_end ? S_END : S_PROBE;
            end
         end
         S_LEN_WAIT: begin
            if (len_rd == in_len) begin
               i_in     = '0;
               state_in = S_CMP;
            end else begin
               off_in   = off_ff + SLOT_W'(1);
               s_in     = s_next;
               state_in = walk_end ? S_END : S_PROBE;
            end
         end
         S_CMP: begin
            if (store_rd != in_rd_byte) begin
               off_in   = off_ff + SLOT_W'(1);
               s_in     = s_next;
               state_in = walk_end ? S_END : S_PROBE;
            end else if (i_ff == in_len - LEN_W'(1)) begin
               res_slot_in   = SLOT_OUT_W'(s_ff);
               res_status_in = ST_FOUND;
               res_byte_in   = '0;
               state_in      = S_DONE;
            end else begin
               i_in = i_ff + LEN_W'(1);
            end
         end
         S_END: begin
            if (avail_vld_ff) begin
               tctrl.set_used = 1'b1;
               tctrl.len_wr   = 1'b1;
               i_in           = '0;
               state_in       = S_COPY;
            end else begin
               res_slot_in   = '0;
               res_status_in = ST_FULL;
               res_byte_in   = '0;
               state_in      = S_DONE;
            end
         end
         S_COPY: begin
            tctrl.store_wr = 1'b1;
            if (i_ff == in_len - LEN_W'(1)) begin
               res_slot_in   = SLOT_OUT_W'(avail_ff);
               res_status_in = ST_INSERTED;
               res_byte_in   = '0;
               state_in      = S_DONE;
            end else begin
               i_in = i_ff + LEN_W'(1);
            end
         end
         S_RD_ISSUE: begin
            res_slot_in = sidx_ff;
            res_byte_in = '0;
            if (32'(sidx_ff) >= TABLE_SLOTS || !used_bit) begin
               res_status_in = ST_EMPTY;
               state_in      = S_DONE;
            end else begin
               res_status_in = ST_FOUND;
               state_in      = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            // zero past the end of the stored name
            if ((BYTE_IDX_W+1)'(bidx_ff) < (BYTE_IDX_W+1)'(len_rd)) begin
               res_byte_in = store_rd;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_byte_in   = res_byte_ff;
               ictrl.clear   = !read_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         avail_vld_ff <= 1'b0;
         read_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         avail_vld_ff <= avail_vld_in;
         read_ff      <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff       <= sidx_in;
      bidx_ff       <= bidx_in;
      s_ff          <= s_in;
      off_ff        <= off_in;
      avail_ff      <= avail_in;
      i_ff          <= i_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.slot      = rsp_slot_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.host_byte = rsp_byte_ff;

   // the modulo unit only reports completion while the sequencer waits for it
   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("modulo done outside modulo wait");

   // byte compare never runs past the incoming name
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> i_ff < in_len)
      else $error("compare index past name length");

   // full and bad length results carry slot and byte zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL || rsp_status_ff == ST_BADLEN)
      |-> rsp_slot_ff == '0 && rsp_byte_ff == '0)
      else $error("failed resolve with nonzero slot or byte");

   // an empty slot read never returns data
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_EMPTY |-> rsp_byte_ff == '0)
      else $error("empty slot read returned data");

endmodule

`default_nettype wire

@@ tb/sv/tb_host_name_slot_table_top.sv @@
// self-checking testbench for the host name slot table top level
`timescale 1ns / 1ps
`default_nettype none

module tb_host_name_slot_table_top;
   import hnst_pkg::*;

   localparam int SLOTS     = 128;
   localparam int NAME_MAX  = 253;
   localparam int IDLE_LIMIT = 200000;

   typedef struct packed {
      logic                  action;
      logic [BYTE_W-1:0]     name_byte;
      logic                  last;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [BYTE_IDX_W-1:0] byte_index;
   } req_item_t;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      status_type            status;
      logic [BYTE_W-1:0]     host_byte;
   } rsp_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hnst_req_if req_bus ();
   hnst_rsp_if rsp_bus ();

   host_name_slot_table_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the table
   bit                table_used [SLOTS];
   int                table_len [SLOTS];
   logic [7:0]        table_bytes [SLOTS][NAME_MAX];
   logic [7:0]        rx_name [NAME_MAX+1];
   int                rx_len;
   logic [31:0]       rx_hash;
   bit                rx_ended;

   req_item_t pending_reqs[$];
   rsp_item_t expected_rsps[$];
   int        errors = 0;
   int        idle_cycles = 0;
   bit        hold_sender = 1'b0;
   int        gap_left = 0;
   int        stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit rx_matches(int s);
      if (table_len[s] != rx_len) return 1'b0;
      for (int i = 0; i < rx_len; i++)
         if (table_bytes[s][i] != rx_name[i]) return 1'b0;
      return 1'b1;
   endfunction

   // probe walk for the name collected so far
   function automatic rsp_item_t lookup_or_insert();
      rsp_item_t r;
      int first, s, free_slot;
      r = '{slot: '0, status: ST_BADLEN, host_byte: '0};
      free_slot = -1;
      if (rx_len == 0 || rx_len > NAME_MAX) return r;
      first = rx_hash % SLOTS;
      for (int off = 0; off < SLOTS; off++) begin
         s = (first + off) % SLOTS;
         if (table_used[s] && rx_matches(s)) begin
            r.slot = SLOT_OUT_W'(s);
            r.status = ST_FOUND;
            return r;
         end
         if (!table_used[s] && free_slot < 0) free_slot = s;
      end
      if (free_slot < 0) begin
         r.status = ST_FULL;
         return r;
      end
      table_used[free_slot] = 1'b1;
      table_len[free_slot] = rx_len;
      for (int i = 0; i < rx_len; i++) table_bytes[free_slot][i] = rx_name[i];
      r.slot = SLOT_OUT_W'(free_slot);
      r.status = ST_INSERTED;
      return r;
   endfunction

   // advance the shadow table by one accepted transfer
   task automatic predict_transfer(input req_item_t it);
      rsp_item_t r;
      if (it.action == ACT_READ) begin
         r = '{slot: it.slot_index, status: ST_EMPTY, host_byte: '0};
         if (table_used[it.slot_index]) begin
            r.status = ST_FOUND;
            if (it.byte_index < table_len[it.slot_index] && it.byte_index < NAME_MAX)
               r.host_byte = table_bytes[it.slot_index][it.byte_index];
         end
         expected_rsps.push_back(r);
         return;
      end
      if (!rx_ended) begin
         if (it.name_byte == 8'd0) begin
            rx_ended = 1'b1;
         end else if (rx_len <= NAME_MAX) begin
            if (rx_len < NAME_MAX) rx_name[rx_len] = it.name_byte;
            rx_len++;
            rx_hash = (rx_hash ^ {24'd0, it.name_byte}) * 32'd16777619;
         end
      end
      if (it.last) begin
         expected_rsps.push_back(lookup_or_insert());
         rx_len = 0;
         rx_hash = 32'd2166136261;
         rx_ended = 1'b0;
      end
   endtask

   // queue one name; body bytes random nonzero, with an occasional zero byte when allow_zero is set
   task automatic queue_name(input int len, input bit allow_zero);
      req_item_t it;
      for (int i = 0; i < len; i++) begin
         it = '{action: ACT_RESOLVE, name_byte: 8'($urandom_range(1, 255)),
                last: (i == len - 1), slot_index: 7'($urandom),
                byte_index: 8'($urandom)};
         if (allow_zero && $urandom_range(0, 29) == 0) it.name_byte = 8'd0;
         pending_reqs.push_back(it);
      end
   endtask

   task automatic queue_fixed(input string s);
      req_item_t it;
      for (int i = 0; i < s.len(); i++) begin
         it = '{action: ACT_RESOLVE, name_byte: s[i], last: (i == s.len() - 1),
                slot_index: '0, byte_index: '0};
         pending_reqs.push_back(it);
      end
   endtask

   task automatic queue_read(input int s, input int b);
      req_item_t it;
      it = '{action: ACT_READ, name_byte: 8'($urandom), last: 1'($urandom),
             slot_index: 7'(s), byte_index: 8'(b)};
      pending_reqs.push_back(it);
   endtask

   // driver: pops pending transfers, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // hold the current transfer
      end else begin
         if (req_bus.valid) begin
            predict_transfer({req_bus.action, req_bus.name_byte, req_bus.last,
                              req_bus.slot_index, req_bus.byte_index});
            gap_left = pick_gap();
         end
         if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_bus.valid <= 1'b0;
         end else begin
            req_item_t it;
            it = pending_reqs.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.action     <= it.action;
            req_bus.name_byte  <= it.name_byte;
            req_bus.last       <= it.last;
            req_bus.slot_index <= it.slot_index;
            req_bus.byte_index <= it.byte_index;
         end
      end
   end

   // monitor: checks each response transfer, random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_item_t exp_r;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response slot=%0d status=%0d byte=%0d", $realtime,
                        rsp_bus.slot, rsp_bus.status, rsp_bus.host_byte);
               errors++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_bus.slot !== exp_r.slot) begin
                  $display("%0t: slot expected %0d actual %0d", $realtime,
                           exp_r.slot, rsp_bus.slot);
                  errors++;
               end
               if (rsp_bus.status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           exp_r.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.host_byte !== exp_r.host_byte) begin
                  $display("%0t: host_byte expected %0d actual %0d", $realtime,
                           exp_r.host_byte, rsp_bus.host_byte);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int len;
      string pool[$];
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_RESOLVE;
      req_bus.name_byte  = '0;
      req_bus.last       = 1'b0;
      req_bus.slot_index = '0;
      req_bus.byte_index = '0;
      rsp_bus.ready      = 1'b0;
      foreach (table_used[i]) begin
         table_used[i] = 1'b0;
         table_len[i] = 0;
      end
      rx_len = 0;
      rx_hash = 32'd2166136261;
      rx_ended = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: read of an empty slot, short names, repeat lookup
      queue_read(0, 0);
      queue_read(127, 255);
      queue_fixed("a");
      queue_fixed("a");
      queue_read(0, 0);
      queue_fixed("ex.org");
      // zero as first byte gives an empty name, zero mid-name cuts it
      pending_reqs.push_back('{ACT_RESOLVE, 8'd0, 1'b1, 7'd0, 8'd0});
      queue_fixed("xy");
      pending_reqs.push_back('{ACT_RESOLVE, 8'hff, 1'b0, 7'd0, 8'd0});
      pending_reqs.push_back('{ACT_RESOLVE, 8'd0, 1'b0, 7'd0, 8'd0});
      pending_reqs.push_back('{ACT_RESOLVE, 8'h41, 1'b1, 7'h7f, 8'hff});
      // longest legal name, then one byte too long
      queue_name(NAME_MAX, 1'b0);
      queue_name(NAME_MAX + 1, 1'b0);
      queue_read(0, 252);
      queue_read(0, 253);

      // wait for the directed part to drain, then hold the sender once
      wait (pending_reqs.size() == 0);
      hold_sender = 1'b1;
      @(posedge clock);
      wait (!req_bus.valid && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;

      // random: mostly short names with reuse mixed with reads, then fill the table, then reads
      for (int n = 0; n < 25; n++) begin
         int r;
         r = $urandom_range(0, 9);
         if (r < 4) begin
            if (pool.size() > 0) queue_fixed(pool[$urandom_range(0, pool.size() - 1)]);
            else queue_name(1, 1'b0);
         end else if (r < 7) begin
            string s;
            len = $urandom_range(1, 6);
            s = "";
            for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range(1, 255)))};
            pool.push_back(s);
            queue_fixed(s);
         end else if (r < 9) begin
            queue_read($urandom_range(0, 127), $urandom_range(0, 7));
         end else begin
            queue_name($urandom_range(1, 12), 1'b1);
         end
      end
      // drive the table to full with distinct one-byte names
      for (int n = 1; n <= 135; n++)
         pending_reqs.push_back('{ACT_RESOLVE, 8'(n), 1'b1, 7'd0, 8'd0});
      for (int n = 0; n < 20; n++) queue_read($urandom_range(0, 127), $urandom_range(0, 255));

      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_bus.valid && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
